[design/rig_pkg.sv]
package rig_pkg;

    localparam int MAX_GROUP  = 64;
    localparam int ELEM_WIDTH = 32;
    localparam int CFG_W      = 7;
    localparam int ADDR_W     = $clog2(MAX_GROUP);
    localparam int CNT_W      = $clog2(MAX_GROUP + 1);

    typedef logic signed [ELEM_WIDTH-1:0] t_elem;
    typedef logic [CFG_W-1:0]             t_cfg;
    typedef logic [ADDR_W-1:0]            t_addr;
    typedef logic [CNT_W-1:0]             t_cnt;

    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic  wr_en;
        t_addr wr_addr;
        logic  rd_en;
        t_addr rd_addr;
    } t_store_ctl;

    function automatic t_cnt eff_size(t_cfg cfg);
        t_cnt size;
        if (cfg == '0) begin
            size = t_cnt'(1);
        end else if (int'(cfg) > MAX_GROUP) begin
            size = t_cnt'(MAX_GROUP);
        end else begin
            size = t_cnt'(cfg);
        end
        return size;
    endfunction

endpackage

[design/rig_if.sv]
interface rig_in_if;
    logic               valid;
    logic               ready;
    rig_pkg::t_elem     element;
    logic               array_end;

    modport source(output valid, output element, output array_end, input ready);
    modport sink(input valid, input element, input array_end, output ready);
endinterface

interface rig_out_if;
    logic               valid;
    logic               ready;
    rig_pkg::t_elem     element_out;
    logic               group_last;
    logic               array_last;

    modport source(output valid, output element_out, output group_last,
                   output array_last, input ready);
    modport sink(input valid, input element_out, input group_last,
                 input array_last, output ready);
endinterface

interface rig_cfg_if;
    logic               valid;
    logic               ready;
    rig_pkg::t_cfg      group_size;

    modport source(output valid, output group_size, input ready);
    modport sink(input valid, input group_size, output ready);
endinterface

[design/reverse_in_groups.sv]
// reverse_in_groups: reverses a stream of array elements in groups.
//
// i_in carries words of one array (element, array_end on its last word).
// o_out returns the same elements reversed within each group, with
// group_last on the last word of every group and array_last on the last
// word of the array. i_cfg writes group_size (1..64; 0 acts as 1, larger
// values as 64); write it only while the block is idle.
//
// Words of a group are written into a 64-entry buffer, one per cycle.
// When a group fills, or array_end arrives, the block stops taking input
// and reads the group back from the top entry down, one read per cycle
// while the output is not stalled. The first reversed word passes
// through the buffer's read register and the output register before it
// shows on o_out. No input is taken while a group is read out, so the
// collection and readout of groups alternate. A stalled receiver holds
// o_out and the read side; input resumes once the last read of the group
// has been issued. Reset clears the fill count and the output valid and
// sets group_size to 1; buffer contents are not cleared.
module reverse_in_groups (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rig_cfg_if.sink     i_cfg,
    rig_in_if.sink      i_in,
    rig_out_if.source   o_out
);

    rig_pkg::t_state     r_state, n_state;
    rig_pkg::t_cfg       r_group_size;
    rig_pkg::t_cnt       r_fill;
    rig_pkg::t_cnt       fill_n;
    rig_pkg::t_addr      r_rd_addr;
    logic                r_arr_end;
    logic                r_q_vld;
    logic                r_q_glast;
    logic                r_q_alast;
    logic                r_out_vld;
    rig_pkg::t_elem      r_out_elem;
    logic                r_out_glast;
    logic                r_out_alast;
    rig_pkg::t_elem      rd_data;
    rig_pkg::t_store_ctl store_ctl;
    logic                in_ready;
    logic                in_acc;
    logic                grp_done;
    logic                out_move;
    logic                rd_issue;

    assign fill_n   = r_fill + rig_pkg::t_cnt'(1);
    assign grp_done = (fill_n >= rig_pkg::eff_size(r_group_size)) || i_in.array_end;
    assign in_acc   = i_in.valid && in_ready;
    assign out_move = !r_out_vld || o_out.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rig_pkg::ST_FILL: begin
                if (in_acc && grp_done) begin
                    n_state = rig_pkg::ST_DRAIN;
                end
            end
            rig_pkg::ST_DRAIN: begin
                if (rd_issue && r_rd_addr == '0) begin
                    n_state = rig_pkg::ST_FILL;
                end
            end
            default: n_state = rig_pkg::ST_FILL;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        rd_issue = 1'b0;
        case (r_state)
            rig_pkg::ST_FILL:  in_ready = 1'b1;
            rig_pkg::ST_DRAIN: rd_issue = !r_q_vld || out_move;
            default: begin
                in_ready = 1'b0;
                rd_issue = 1'b0;
            end
        endcase
    end

    assign store_ctl.wr_en   = in_acc;
    assign store_ctl.wr_addr = r_fill[rig_pkg::ADDR_W-1:0];
    assign store_ctl.rd_en   = rd_issue;
    assign store_ctl.rd_addr = r_rd_addr;

    rig_store u_store (
        .i_clk     (i_clk),
        .i_ctl     (store_ctl),
        .i_wr_data (i_in.element),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rig_pkg::ST_FILL;
            r_group_size <= rig_pkg::t_cfg'(1);
            r_fill       <= '0;
            r_q_vld      <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_group_size <= i_cfg.group_size;
            end
            if (in_acc) begin
                r_fill <= grp_done ? '0 : fill_n;
            end
            if (rd_issue) begin
                r_q_vld <= 1'b1;
            end else if (out_move) begin
                r_q_vld <= 1'b0;
            end
            if (out_move) begin
                r_out_vld <= r_q_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && grp_done) begin
            r_rd_addr <= r_fill[rig_pkg::ADDR_W-1:0];
            r_arr_end <= i_in.array_end;
        end else if (rd_issue) begin
            r_rd_addr <= r_rd_addr - rig_pkg::t_addr'(1);
        end
        if (rd_issue) begin
            r_q_glast <= (r_rd_addr == '0);
            r_q_alast <= (r_rd_addr == '0) && r_arr_end;
        end
        if (out_move) begin
            r_out_elem  <= rd_data;
            r_out_glast <= r_q_glast;
            r_out_alast <= r_q_alast;
        end
    end

    assign i_cfg.ready       = 1'b1;
    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_vld;
    assign o_out.element_out = r_out_elem;
    assign o_out.group_last  = r_out_glast;
    assign o_out.array_last  = r_out_alast;

    a_alast_glast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.array_last |-> o_out.group_last)
        else $error("array_last without group_last");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rig_pkg::ST_DRAIN |-> r_fill == '0)
        else $error("fill count not cleared during readout");

    a_q_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_vld && !out_move |=> r_q_vld && $stable(rd_data))
        else $error("read data lost under stall");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) < rig_pkg::MAX_GROUP)
        else $error("fill count out of range");

endmodule

[design/rig_store.sv]
module rig_store (
    input  logic                i_clk,
    input  rig_pkg::t_store_ctl i_ctl,
    input  rig_pkg::t_elem      i_wr_data,
    output rig_pkg::t_elem      o_rd_data
);

    rig_pkg::t_elem r_mem [rig_pkg::MAX_GROUP];
    rig_pkg::t_elem r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
